/* rtl/assert_macros.svh */
// Assertion helpers; clk and rst are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vat_pkg.sv */
`default_nettype none

package vat_pkg;

  localparam int SIDE_LEN  = 4;
  localparam int FRAC_BITS = 16;
  localparam int NUM_COMP  = 4;
  localparam int NUM_PAIRS = 8;
  localparam int NUM_ELEM  = 2 * NUM_PAIRS;
  localparam int COMP_W    = 32;
  localparam int DIM_W     = 3;
  localparam int REG_W     = 64;
  localparam int IDX_W     = $clog2(NUM_PAIRS);
  localparam int PROD_W    = 2 * COMP_W;
  localparam int HALF_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int SH_W      = ACC_W - FRAC_BITS;
  localparam int RES_W     = SH_W + 1;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [REG_W-1:0]         coeff_reg_t;
  typedef logic [IDX_W-1:0]         reg_idx_t;

  localparam comp_t COMP_MAX = comp_t'(32'sh7fff_ffff);
  localparam comp_t COMP_MIN = comp_t'(32'sh8000_0000);

  // Identity matrix.
  localparam coeff_reg_t COEFF_RESET [NUM_PAIRS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

`default_nettype wire

/* rtl/vat_in_if.sv */
`default_nettype none

interface vat_in_if;
  import vat_pkg::*;

  logic  valid;
  logic  ready;
  comp_t comp_x;
  comp_t comp_y;
  comp_t comp_z;
  comp_t comp_w;
  dim_t  components_used;
  logic  add_translation;
  logic  last_vertex;

  modport source (
    output valid, comp_x, comp_y, comp_z, comp_w, components_used, add_translation,
           last_vertex,
    input  ready
  );

  modport sink (
    input  valid, comp_x, comp_y, comp_z, comp_w, components_used, add_translation,
           last_vertex,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/vat_out_if.sv */
`default_nettype none

interface vat_out_if;
  import vat_pkg::*;

  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;
  logic  saturated;
  logic  last_vertex_out;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated, last_vertex_out,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated, last_vertex_out,
    output ready
  );

endinterface

`default_nettype wire

/* rtl/vertex_affine_transform.sv */
// A request passes through stages one to four into the output register; output stalls hold it.
// Throughput: one request per cycle unless the output stalls.
// Sixteen parallel 32x32 multipliers feed an adder tree.
// Each stage holds its data only while the stage after it is full, so bubbles are squeezed out.
// Reset clears every stage valid bit and loads the identity matrix into the coefficients.
`default_nettype none

`include "assert_macros.svh"

module vertex_affine_transform (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr_en,
  input  wire vat_pkg::reg_idx_t   wr_index,
  input  wire vat_pkg::coeff_reg_t wr_data,
  vat_in_if.sink             vertex,
  vat_out_if.source          result
);
  import vat_pkg::*;

  coeff_reg_t coeff_regs [NUM_PAIRS];
  comp_t      coef [NUM_ELEM];

  logic [5:1] vld;
  logic [5:1] adv;

  comp_t src_in [NUM_COMP];
  dim_t  dim_in;
  logic  trans_in;

  comp_t s1_src [NUM_COMP];
  dim_t  s1_dim;
  logic  s1_trans;
  logic  s1_last;

  logic signed [PROD_W-1:0] s2_prod [NUM_COMP][NUM_COMP];
  dim_t  s2_dim;
  logic  s2_trans;
  logic  s2_last;

  logic signed [HALF_W-1:0] s3_half [NUM_COMP][2];
  dim_t  s3_dim;
  logic  s3_trans;
  logic  s3_last;

  logic signed [RES_W-1:0] s4_res [NUM_COMP];
  logic signed [RES_W-1:0] res_next [NUM_COMP];
  dim_t  s4_dim;
  logic  s4_last;

  comp_t o_comp [NUM_COMP];
  comp_t o_comp_next [NUM_COMP];
  logic  o_sat;
  logic  o_sat_next;
  logic  o_last;
  dim_t  o_dim;

  logic                one_lane;
  logic                upper_zero;
  logic [NUM_COMP-1:0] at_limit;

  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(COMP_MAX);
  localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(COMP_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
        coeff_regs[i] <= COEFF_RESET[i];
      end
    end else if (wr_en) begin
      coeff_regs[wr_index] <= wr_data;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      coef[k] = k[0] ? comp_t'(coeff_regs[k / 2][REG_W-1:COMP_W])
                     : comp_t'(coeff_regs[k / 2][COMP_W-1:0]);
    end
  end

  always_comb begin
    adv[5] = !vld[5] || result.ready;
    for (int i = 4; i >= 1; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign vertex.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= vertex.valid;
      end
      for (int i = 2; i <= 5; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    src_in[0] = vertex.comp_x;
    src_in[1] = vertex.comp_y;
    src_in[2] = vertex.comp_z;
    src_in[3] = vertex.comp_w;
    if (vertex.components_used == '0) begin
      dim_in = dim_t'(1);
    end else if (vertex.components_used > dim_t'(SIDE_LEN)) begin
      dim_in = dim_t'(SIDE_LEN);
    end else begin
      dim_in = vertex.components_used;
    end
    trans_in = vertex.add_translation && (dim_in < dim_t'(SIDE_LEN));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int m = 0; m < NUM_COMP; m++) begin
        s1_src[m] <= (dim_t'(m) < dim_in) ? src_in[m] : '0;
      end
      s1_dim   <= dim_in;
      s1_trans <= trans_in;
      s1_last  <= vertex.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        for (int m = 0; m < NUM_COMP; m++) begin
          if (m < SIDE_LEN && c < SIDE_LEN) begin
            s2_prod[c][m] <= s1_src[m] * coef[m * SIDE_LEN + c];
          end else begin
            s2_prod[c][m] <= '0;
          end
        end
      end
      s2_dim   <= s1_dim;
      s2_trans <= s1_trans;
      s2_last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        s3_half[c][0] <= HALF_W'(s2_prod[c][0]) + HALF_W'(s2_prod[c][1]);
        s3_half[c][1] <= HALF_W'(s2_prod[c][2]) + HALF_W'(s2_prod[c][3]);
      end
      s3_dim   <= s2_dim;
      s3_trans <= s2_trans;
      s3_last  <= s2_last;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  shifted;
    comp_t                   shift_add;
    for (int c = 0; c < NUM_COMP; c++) begin
      acc       = ACC_W'(s3_half[c][0]) + ACC_W'(s3_half[c][1]);
      shifted   = SH_W'(acc >>> FRAC_BITS);
      shift_add = (s3_trans && c < SIDE_LEN) ? coef[(SIDE_LEN - 1) * SIDE_LEN + c] : '0;
      res_next[c] = RES_W'(shifted) + RES_W'(shift_add);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        s4_res[c] <= res_next[c];
      end
      s4_dim  <= s3_dim;
      s4_last <= s3_last;
    end
  end

  always_comb begin
    o_sat_next = 1'b0;
    for (int c = 0; c < NUM_COMP; c++) begin
      if (dim_t'(c) >= s4_dim) begin
        o_comp_next[c] = '0;
      end else if (s4_res[c] > SAT_MAX) begin
        o_comp_next[c] = COMP_MAX;
        o_sat_next     = 1'b1;
      end else if (s4_res[c] < SAT_MIN) begin
        o_comp_next[c] = COMP_MIN;
        o_sat_next     = 1'b1;
      end else begin
        o_comp_next[c] = comp_t'(s4_res[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        o_comp[c] <= o_comp_next[c];
      end
      o_sat  <= o_sat_next;
      o_last <= s4_last;
      o_dim  <= s4_dim;
    end
  end

  assign result.valid           = vld[5];
  assign result.out_x           = o_comp[0];
  assign result.out_y           = o_comp[1];
  assign result.out_z           = o_comp[2];
  assign result.out_w           = o_comp[3];
  assign result.saturated       = o_sat;
  assign result.last_vertex_out = o_last;

  always_comb begin
    one_lane   = (o_dim == dim_t'(1));
    upper_zero = (o_comp[1] == '0) && (o_comp[2] == '0) && (o_comp[3] == '0);
    for (int c = 0; c < NUM_COMP; c++) begin
      at_limit[c] = (o_comp[c] == COMP_MAX) || (o_comp[c] == COMP_MIN);
    end
  end

  `ASSERT_NEXT(a_accept_enters, vertex.valid && vertex.ready, vld[1], "accepted request lost")
  `ASSERT_NEXT(a_stall_holds, vld[4] && !adv[4], vld[4], "stalled stage four dropped its request")
  `ASSERT_IMPLIES(a_unused_zero, result.valid && one_lane, upper_zero, "unused lanes not zero")
  `ASSERT_IMPLIES(a_sat_extreme, result.valid && o_sat, |at_limit, "flag without a clipped lane")

endmodule

`default_nettype wire

/* test/tb_vertex_affine_transform.sv */
`timescale 1ns / 1ps

module tb_vertex_affine_transform;
  import vat_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    comp_t comp_x;
    comp_t comp_y;
    comp_t comp_z;
    comp_t comp_w;
    dim_t  components_used;
    logic  add_translation;
    logic  last_vertex;
  } vertex_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  saturated;
    logic  last_vertex_out;
  } xform_t;

  typedef enum int {
    MAT_IDENTITY, MAT_MIXED, MAT_ALL_MAX, MAT_ALL_MIN, MAT_ZERO, MAT_ALL_ONES,
    MAT_RANDOM, MAT_SMALL
  } matrix_kind_t;

  class vertex_scoreboard;
    comp_t  matrix [NUM_ELEM];
    xform_t expected_q [$];
    int     mismatches;
    int     checked;
    int     clipped;

    function new();
      for (int p = 0; p < NUM_PAIRS; p++) begin
        load_pair(p, COEFF_RESET[p]);
      end
      mismatches = 0;
      checked = 0;
      clipped = 0;
    endfunction

    function void load_pair(int idx, coeff_reg_t data);
      matrix[2*idx]   = data[31:0];
      matrix[2*idx+1] = data[63:32];
    endfunction

    function xform_t transform(vertex_t v);
      xform_t r;
      comp_t src [NUM_COMP];
      comp_t res [NUM_COMP];
      logic signed [67:0] acc;
      logic signed [67:0] a;
      logic signed [67:0] b;
      int dim;
      src[0] = v.comp_x;
      src[1] = v.comp_y;
      src[2] = v.comp_z;
      src[3] = v.comp_w;
      dim = v.components_used;
      if (dim == 0) dim = 1;
      if (dim > SIDE_LEN) dim = SIDE_LEN;
      r.saturated = 1'b0;
      for (int c = 0; c < NUM_COMP; c++) begin
        res[c] = '0;
        if (c < dim) begin
          acc = '0;
          for (int m = 0; m < dim; m++) begin
            a = src[m];
            b = matrix[m*SIDE_LEN + c];
            acc = acc + a * b;
          end
          acc = acc >>> FRAC_BITS;
          if (v.add_translation && dim < SIDE_LEN) begin
            b = matrix[(SIDE_LEN-1)*SIDE_LEN + c];
            acc = acc + b;
          end
          if (acc > COMP_MAX) begin
            res[c] = COMP_MAX;
            r.saturated = 1'b1;
          end else if (acc < COMP_MIN) begin
            res[c] = COMP_MIN;
            r.saturated = 1'b1;
          end else begin
            res[c] = acc[31:0];
          end
        end
      end
      r.out_x = res[0];
      r.out_y = res[1];
      r.out_z = res[2];
      r.out_w = res[3];
      r.last_vertex_out = v.last_vertex;
      return r;
    endfunction

    function void note_request(vertex_t v);
      expected_q.push_back(transform(v));
    endfunction

    function void check_result(xform_t got);
      xform_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result with no request pending: x=%h y=%h z=%h w=%h sat=%b last=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w, got.saturated,
                   got.last_vertex_out);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.saturated) clipped++;
      if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
          got.out_z !== exp_r.out_z || got.out_w !== exp_r.out_w ||
          got.saturated !== exp_r.saturated ||
          got.last_vertex_out !== exp_r.last_vertex_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d: expected x=%h y=%h z=%h w=%h sat=%b last=%b",
                   checked, exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.out_w,
                   exp_r.saturated, exp_r.last_vertex_out);
          $display("  actual x=%h y=%h z=%h w=%h sat=%b last=%b",
                   got.out_x, got.out_y, got.out_z, got.out_w, got.saturated,
                   got.last_vertex_out);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic wr_en;
  reg_idx_t wr_index;
  coeff_reg_t wr_data;

  vat_in_if  vin ();
  vat_out_if vout ();

  vertex_affine_transform dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .vertex   (vin),
    .result   (vout)
  );

  vertex_scoreboard sb = new();
  int cycle_count;
  int settings_used;
  bit hold_off_req;
  vertex_t seen_v;
  xform_t seen_r;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vin.valid && vin.ready) begin
        seen_v.comp_x = vin.comp_x;
        seen_v.comp_y = vin.comp_y;
        seen_v.comp_z = vin.comp_z;
        seen_v.comp_w = vin.comp_w;
        seen_v.components_used = vin.components_used;
        seen_v.add_translation = vin.add_translation;
        seen_v.last_vertex = vin.last_vertex;
        sb.note_request(seen_v);
      end
      if (vout.valid && vout.ready) begin
        seen_r.out_x = vout.out_x;
        seen_r.out_y = vout.out_y;
        seen_r.out_z = vout.out_z;
        seen_r.out_w = vout.out_w;
        seen_r.saturated = vout.saturated;
        seen_r.last_vertex_out = vout.last_vertex_out;
        sb.check_result(seen_r);
      end
    end
  end

  // The output side switches between stall patterns; on request it holds off for a long stretch.
  initial begin
    int rx_mode;
    int left;
    vout.ready <= 1'b0;
    rx_mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        vout.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        rx_mode = $urandom_range(0, 3);
        left = $urandom_range(16, 128);
      end
      left--;
      case (rx_mode)
        0: vout.ready <= 1'b1;
        1: vout.ready <= 1'($urandom_range(0, 1));
        2: vout.ready <= ($urandom_range(0, 3) == 0);
        default: vout.ready <= (left % 3 != 0);
      endcase
    end
  end

  function automatic vertex_t make_vertex(comp_t x, comp_t y, comp_t z, comp_t w, int dim,
                                          bit translate, bit last);
    vertex_t v;
    v.comp_x = x;
    v.comp_y = y;
    v.comp_z = z;
    v.comp_w = w;
    v.components_used = dim_t'(dim);
    v.add_translation = translate;
    v.last_vertex = last;
    return v;
  endfunction

  function automatic comp_t rand_value();
    case ($urandom_range(0, 7))
      0: return COMP_MAX;
      1: return COMP_MIN;
      2, 3: return comp_t'($urandom_range(0, 524288) - 262144);
      default: return comp_t'($urandom());
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    int dim;
    if ($urandom_range(0, 9) < 8) dim = $urandom_range(1, 4);
    else dim = $urandom_range(0, 7);
    return make_vertex(rand_value(), rand_value(), rand_value(), rand_value(), dim,
                       1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
  endfunction

  task automatic push_vertex(vertex_t v);
    vin.valid <= 1'b1;
    vin.comp_x <= v.comp_x;
    vin.comp_y <= v.comp_y;
    vin.comp_z <= v.comp_z;
    vin.comp_w <= v.comp_w;
    vin.components_used <= v.components_used;
    vin.add_translation <= v.add_translation;
    vin.last_vertex <= v.last_vertex;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
  endtask

  task automatic pause(int n);
    vin.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    vin.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coeff(int idx, coeff_reg_t data);
    wr_en <= 1'b1;
    wr_index <= reg_idx_t'(idx);
    wr_data <= data;
    sb.load_pair(idx, data);
    @(posedge clk);
  endtask

  task automatic load_matrix(matrix_kind_t kind);
    coeff_reg_t data;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      case (kind)
        MAT_IDENTITY: data = COEFF_RESET[p];
        MAT_MIXED:    data = {rand_value(), rand_value()};
        MAT_ALL_MAX:  data = {COMP_MAX, COMP_MAX};
        MAT_ALL_MIN:  data = {COMP_MIN, COMP_MIN};
        MAT_ZERO:     data = '0;
        MAT_ALL_ONES: data = '1;
        MAT_SMALL:    data = {32'($urandom_range(0, 524288) - 262144),
                              32'($urandom_range(0, 524288) - 262144)};
        default:      data = {$urandom(), $urandom()};
      endcase
      write_coeff(p, data);
    end
    wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic stream_random(int count);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 32);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause(gap);
      end
      push_vertex(rand_vertex());
      burst--;
    end
  endtask

  initial begin
    matrix_kind_t plan [10];
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    vin.valid <= 1'b0;
    vin.comp_x <= '0;
    vin.comp_y <= '0;
    vin.comp_z <= '0;
    vin.comp_w <= '0;
    vin.components_used <= '0;
    vin.add_translation <= 1'b0;
    vin.last_vertex <= 1'b0;
    hold_off_req = 1'b0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity after reset: full-range values pass through, unused lanes are zero.
    push_vertex(make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 4, 0, 0));
    push_vertex(make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 4, 1, 1));
    push_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0));
    push_vertex(make_vertex(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f, -1, 1, 1, 0));
    push_vertex(make_vertex(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f, -1, 2, 0, 1));
    push_vertex(make_vertex(-1, -1, -1, -1, 3, 1, 0));
    push_vertex(make_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 5, 0, 0));
    push_vertex(make_vertex(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 6, 1, 1));
    push_vertex(make_vertex(COMP_MAX, COMP_MIN, 1, -1, 7, 1, 0));
    drain();

    // A hand-built matrix with extreme elements and a nonzero translation column.
    write_coeff(0, {32'h8000_0000, 32'h7fff_ffff});
    write_coeff(1, {32'hffff_0000, 32'h0001_0000});
    write_coeff(2, {32'h7fff_ffff, 32'h0000_8000});
    write_coeff(3, {32'h0000_0001, 32'hffff_ffff});
    write_coeff(4, {32'h0002_0000, 32'hfffe_8000});
    write_coeff(5, {32'h8000_0000, 32'h0000_4000});
    write_coeff(6, {32'h8000_0000, 32'h7fff_ffff});
    write_coeff(7, {32'h8000_0000, 32'h0001_8000});
    wr_en <= 1'b0;
    settings_used++;
    push_vertex(make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 4, 0, 0));
    push_vertex(make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 4, 0, 1));
    push_vertex(make_vertex(COMP_MAX, COMP_MIN, 0, 0, 2, 1, 0));
    push_vertex(make_vertex(32'h0001_0000, 0, 0, 0, 1, 1, 0));
    push_vertex(make_vertex(-1, 0, 0, 0, 1, 0, 0));
    push_vertex(make_vertex(-3, 5, -7, 0, 3, 0, 1));
    push_vertex(make_vertex(32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 0, 3, 1, 0));
    push_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            4, 1, 0));
    push_vertex(make_vertex(32'h0001_0000, 32'h0002_0000, 0, 0, 0, 1, 1));
    push_vertex(make_vertex(1, 2, 3, 4, 5, 1, 0));
    push_vertex(make_vertex(COMP_MIN, 1, COMP_MAX, -1, 6, 0, 0));
    push_vertex(make_vertex(COMP_MAX, COMP_MAX, COMP_MIN, COMP_MIN, 7, 1, 1));
    drain();

    plan = '{MAT_RANDOM, MAT_MIXED, MAT_ALL_MAX, MAT_ALL_MIN, MAT_SMALL, MAT_MIXED,
             MAT_ZERO, MAT_ALL_ONES, MAT_IDENTITY, MAT_RANDOM};
    for (int ph = 0; ph < 10; ph++) begin
      load_matrix(plan[ph]);
      if (ph == 1) begin
        // Keep offering requests while the output side is held off.
        hold_off_req = 1'b1;
        for (int i = 0; i < 80; i++) push_vertex(rand_vertex());
      end
      stream_random(PHASE_ITEMS);
      drain();
    end

    $display("Transformed %0d vertices under %0d coefficient settings, %0d of them clipped.",
             sb.checked, settings_used, sb.clipped);
    $display("Mismatches: %0d, results still outstanding: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/vat_pkg.sv
rtl/vat_in_if.sv
rtl/vat_out_if.sv
rtl/vertex_affine_transform.sv
test/tb_vertex_affine_transform.sv
